FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies; compiled first, included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: sv/rofk_pkg.sv
// Package for the rigid offset frame kinematics unit: format constants, register indexes.
// No dependencies.
`default_nettype none
package rofk_pkg;
  localparam int unsigned LaneBits = 16;
  localparam int unsigned FracBits = 12;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 48;
  typedef enum logic [CfgIdxBits-1:0] {
    REG_OFFSET_POS  = 2'd0,
    REG_OFFSET_ROW0 = 2'd1,
    REG_OFFSET_ROW1 = 2'd2,
    REG_OFFSET_ROW2 = 2'd3
  } cfg_reg_e;
endpackage
`default_nettype wire

FILE: sv/rofk_in_if.sv
// Input and output channel interfaces (valid/ready with packed payload).
// Depends on nothing; widths come from the LW parameter.
`default_nettype none
interface rofk_in_if #(parameter int unsigned LW = 16);
  logic valid;
  logic ready;
  logic [3*LW-1:0] ref_orient_row0;
  logic [3*LW-1:0] ref_orient_row1;
  logic [3*LW-1:0] ref_orient_row2;
  logic [3*LW-1:0] ref_position;
  logic [3*LW-1:0] ref_velocity;
  logic [3*LW-1:0] ref_ang_velocity;
  logic [3*LW-1:0] ref_acceleration;
  logic [3*LW-1:0] ref_ang_acceleration;
  modport source (output valid, ref_orient_row0, ref_orient_row1, ref_orient_row2,
    ref_position, ref_velocity, ref_ang_velocity, ref_acceleration,
    ref_ang_acceleration, input ready);
  modport sink (input valid, ref_orient_row0, ref_orient_row1, ref_orient_row2,
    ref_position, ref_velocity, ref_ang_velocity, ref_acceleration,
    ref_ang_acceleration, output ready);
endinterface

interface rofk_out_if #(parameter int unsigned LW = 16);
  logic valid;
  logic ready;
  logic [3*LW-1:0] out_orient_row0;
  logic [3*LW-1:0] out_orient_row1;
  logic [3*LW-1:0] out_orient_row2;
  logic [3*LW-1:0] world_offset;
  logic [3*LW-1:0] out_position;
  logic [3*LW-1:0] out_velocity;
  logic [3*LW-1:0] out_ang_velocity;
  logic [3*LW-1:0] out_acceleration;
  logic [3*LW-1:0] out_ang_acceleration;
  modport source (output valid, out_orient_row0, out_orient_row1, out_orient_row2,
    world_offset, out_position, out_velocity, out_ang_velocity, out_acceleration,
    out_ang_acceleration, input ready);
  modport sink (input valid, out_orient_row0, out_orient_row1, out_orient_row2,
    world_offset, out_position, out_velocity, out_ang_velocity, out_acceleration,
    out_ang_acceleration, output ready);
endinterface
`default_nettype wire

FILE: sv/rigid_offset_frame_kinematics_unit.sv
// Rigid offset frame kinematics: derives the state of a frame fixed to a reference frame.
// Pipeline of six register stages; one item accepted each cycle while the output is not
// stalled, and each result leaves from the sixth stage. The pipeline depth is set by the
// dependent chain r -> w x r -> w x (w x r), each a multiply stage then a round/sum stage.
// The whole pipeline advances together; a stalled output holds every stage, and an empty
// output slot lets the pipe move. Depends on rofk_pkg, rofk_in_if, assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none
module rigid_offset_frame_kinematics_unit #(
  parameter int unsigned LANE_BITS = rofk_pkg::LaneBits,
  parameter int unsigned FRAC_BITS = rofk_pkg::FracBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [rofk_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [3*LANE_BITS-1:0] cfg_data_i,
  rofk_in_if.sink  in_if,
  rofk_out_if.source out_if
);
  import rofk_pkg::*;

  localparam int unsigned LW = LANE_BITS;
  localparam int unsigned FW = 3 * LW;
  localparam int unsigned PW = 2 * LW;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned NST = 6;

  typedef logic signed [LW-1:0] lane_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;
  typedef lane_t [2:0] vec_t;

  localparam lane_t LaneMax = lane_t'({1'b0, {(LW-1){1'b1}}});
  localparam lane_t LaneMin = lane_t'({1'b1, {(LW-1){1'b0}}});
  localparam sum_t RoundK = sum_t'(1) <<< (FRAC_BITS - 1);

  function automatic vec_t unpk(input logic [FW-1:0] w);
    vec_t v;
    for (int i = 0; i < 3; i++) v[i] = w[i*LW +: LW];
    return v;
  endfunction

  function automatic logic [FW-1:0] pk(input vec_t v);
    return {v[2], v[1], v[0]};
  endfunction

  function automatic lane_t rsat(input sum_t x);
    sum_t q;
    q = (x + RoundK) >>> FRAC_BITS;
    if (q > sum_t'(LaneMax)) return LaneMax;
    if (q < sum_t'(LaneMin)) return LaneMin;
    return lane_t'(q);
  endfunction

  function automatic lane_t sat3(input lane_t a, input lane_t b, input lane_t c);
    logic signed [LW+1:0] s;
    s = (LW+2)'(a) + (LW+2)'(b) + (LW+2)'(c);
    if (s > (LW+2)'(LaneMax)) return LaneMax;
    if (s < (LW+2)'(LaneMin)) return LaneMin;
    return lane_t'(s);
  endfunction

  function automatic prod_t mul(input lane_t a, input lane_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // Configuration
  logic [FW-1:0] p_q, b0_q, b1_q, b2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q  <= '0;
      b0_q <= FW'(1) << FRAC_BITS;
      b1_q <= FW'(1) << (FRAC_BITS + LW);
      b2_q <= FW'(1) << (FRAC_BITS + 2*LW);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_OFFSET_POS:  p_q  <= cfg_data_i;
        REG_OFFSET_ROW0: b0_q <= cfg_data_i;
        REG_OFFSET_ROW1: b1_q <= cfg_data_i;
        REG_OFFSET_ROW2: b2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [NST-1:0] vld_q;
  logic adv;
  assign adv = !vld_q[NST-1] || out_if.ready;
  assign in_if.ready = adv;
  assign out_if.valid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NST-2:0], in_if.valid};
  end

  // Stage 1: products for A*B and A*p
  prod_t ab_pr_q [3][3][3];
  prod_t r_pr_q [3][3];
  vec_t pos1_q, v1_q, w1_q, a1_q, al1_q;
  // Stage 2: rounded r and A*B
  vec_t r2_q, ab2_q [3], pos2_q, v2_q, w2_q, a2_q, al2_q;
  // Stage 3: cross products with r
  prod_t wr_pr_q [3][2], alr_pr_q [3][2];
  vec_t r3_q, ab3_q [3], pos3_q, v3_q, w3_q, a3_q, al3_q;
  // Stage 4: rounded w x r, alpha x r; sum for position
  vec_t wr4_q, alr4_q, r4_q, ab4_q [3], op4_q, ov4_q, w4_q, a4_q, al4_q;
  // Stage 5: products for w x (w x r); sum for velocity
  prod_t wwr_pr_q [3][2];
  vec_t alr5_q, r5_q, ab5_q [3], op5_q, ov5_q, w5_q, a5_q, al5_q;
  // Stage 6: output register
  vec_t oa6_q, r6_q, ab6_q [3], op6_q, ov6_q, w6_q, al6_q;

  vec_t ain [3], bin [3], pin;
  always_comb begin
    ain[0] = unpk(in_if.ref_orient_row0);
    ain[1] = unpk(in_if.ref_orient_row1);
    ain[2] = unpk(in_if.ref_orient_row2);
    bin[0] = unpk(b0_q);
    bin[1] = unpk(b1_q);
    bin[2] = unpk(b2_q);
    pin = unpk(p_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) ab_pr_q[i][j][k] <= mul(ain[i][k], bin[k][j]);
          r_pr_q[i][j] <= mul(ain[i][j], pin[j]);
        end
      end
      pos1_q <= unpk(in_if.ref_position);
      v1_q   <= unpk(in_if.ref_velocity);
      w1_q   <= unpk(in_if.ref_ang_velocity);
      a1_q   <= unpk(in_if.ref_acceleration);
      al1_q  <= unpk(in_if.ref_ang_acceleration);

      for (int i = 0; i < 3; i++) begin
        r2_q[i] <= rsat(sum_t'(r_pr_q[i][0]) + sum_t'(r_pr_q[i][1]) + sum_t'(r_pr_q[i][2]));
        for (int j = 0; j < 3; j++)
          ab2_q[i][j] <= rsat(sum_t'(ab_pr_q[i][j][0]) + sum_t'(ab_pr_q[i][j][1])
                              + sum_t'(ab_pr_q[i][j][2]));
      end
      pos2_q <= pos1_q; v2_q <= v1_q; w2_q <= w1_q; a2_q <= a1_q; al2_q <= al1_q;

      for (int i = 0; i < 3; i++) begin
        wr_pr_q[i][0]  <= mul(w2_q[(i+1)%3], r2_q[(i+2)%3]);
        wr_pr_q[i][1]  <= mul(w2_q[(i+2)%3], r2_q[(i+1)%3]);
        alr_pr_q[i][0] <= mul(al2_q[(i+1)%3], r2_q[(i+2)%3]);
        alr_pr_q[i][1] <= mul(al2_q[(i+2)%3], r2_q[(i+1)%3]);
      end
      r3_q <= r2_q; ab3_q <= ab2_q; pos3_q <= pos2_q; v3_q <= v2_q;
      w3_q <= w2_q; a3_q <= a2_q; al3_q <= al2_q;

      for (int i = 0; i < 3; i++) begin
        wr4_q[i]  <= rsat(sum_t'(wr_pr_q[i][0]) - sum_t'(wr_pr_q[i][1]));
        alr4_q[i] <= rsat(sum_t'(alr_pr_q[i][0]) - sum_t'(alr_pr_q[i][1]));
        op4_q[i]  <= sat3(pos3_q[i], r3_q[i], '0);
        ov4_q[i]  <= sat3(v3_q[i], '0, '0);
      end
      r4_q <= r3_q; ab4_q <= ab3_q; w4_q <= w3_q; a4_q <= a3_q; al4_q <= al3_q;

      for (int i = 0; i < 3; i++) begin
        wwr_pr_q[i][0] <= mul(w4_q[(i+1)%3], wr4_q[(i+2)%3]);
        wwr_pr_q[i][1] <= mul(w4_q[(i+2)%3], wr4_q[(i+1)%3]);
        ov5_q[i] <= sat3(ov4_q[i], wr4_q[i], '0);
      end
      alr5_q <= alr4_q; r5_q <= r4_q; ab5_q <= ab4_q; op5_q <= op4_q;
      w5_q <= w4_q; a5_q <= a4_q; al5_q <= al4_q;

      for (int i = 0; i < 3; i++)
        oa6_q[i] <= sat3(a5_q[i], alr5_q[i],
                         rsat(sum_t'(wwr_pr_q[i][0]) - sum_t'(wwr_pr_q[i][1])));
      r6_q <= r5_q; ab6_q <= ab5_q; op6_q <= op5_q; ov6_q <= ov5_q;
      w6_q <= w5_q; al6_q <= al5_q;
    end
  end

  assign out_if.out_orient_row0      = pk(ab6_q[0]);
  assign out_if.out_orient_row1      = pk(ab6_q[1]);
  assign out_if.out_orient_row2      = pk(ab6_q[2]);
  assign out_if.world_offset         = pk(r6_q);
  assign out_if.out_position         = pk(op6_q);
  assign out_if.out_velocity         = pk(ov6_q);
  assign out_if.out_ang_velocity     = pk(w6_q);
  assign out_if.out_acceleration     = pk(oa6_q);
  assign out_if.out_ang_acceleration = pk(al6_q);

  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, vld_q == $past(vld_q), "pipeline moved during stall")
  `ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_if.valid |-> in_if.ready, "ready low with empty output")
  `ASSERT_NEXT(a_in_tracks, clk_i, rst_ni, in_if.valid && in_if.ready, vld_q[0], "accepted transfer lost")
endmodule
`default_nettype wire
